@@ rtl/core/bbn_pkg.sv @@
// ----------------------------------------------------------------------------
// bbn_pkg
// shared types and constants of the bounding box normaliser
// ----------------------------------------------------------------------------
`default_nettype none

package bbn_pkg;

  localparam int unsigned AXES    = 3;
  localparam int unsigned CHUNK_W = 16;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_DIV,
    ST_MLOAD,
    ST_MUL,
    ST_NSTORE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic  upd_bounds;
    logic  load_point;
    logic  span_clr;
    logic  span_step;
    logic  div_init;
    logic  div_step;
    logic  div_first;
    logic  mul_load;
    logic  mul_step;
    logic  norm_store;
    logic  out_load;
    axis_e axis;
  } bbn_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/bbn_in_if.sv @@
// ----------------------------------------------------------------------------
// bbn_in_if
// point channel: valid/ready handshake with one point per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface bbn_in_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] coord_z;
  logic                          pass;
  logic                          first;
  logic                          last;

  modport source (
    output valid, coord_x, coord_y, coord_z, pass, first, last,
    input  ready
  );

  modport sink (
    input  valid, coord_x, coord_y, coord_z, pass, first, last,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/bbn_out_if.sv @@
// ----------------------------------------------------------------------------
// bbn_out_if
// result channel: valid/ready handshake with one normalised point per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface bbn_out_if #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned OUT_FRAC_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [OUT_FRAC_BITS:0]        norm_x;
  logic [OUT_FRAC_BITS:0]        norm_y;
  logic [OUT_FRAC_BITS:0]        norm_z;
  logic                          is_last;
  logic [COORD_WIDTH-1:0]        span;
  logic signed [COORD_WIDTH-1:0] low_x;
  logic signed [COORD_WIDTH-1:0] low_y;
  logic signed [COORD_WIDTH-1:0] low_z;

  modport source (
    output valid, norm_x, norm_y, norm_z, is_last, span, low_x, low_y, low_z,
    input  ready
  );

  modport sink (
    input  valid, norm_x, norm_y, norm_z, is_last, span, low_x, low_y, low_z,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/bbn_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbn_ctrl
// sequencer: span search, reciprocal division, per-axis multiply and output
// ----------------------------------------------------------------------------
`default_nettype none

module bbn_ctrl #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_pass_i,
  input  logic              in_first_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output bbn_pkg::bbn_cmd_t cmd_o
);
  import bbn_pkg::*;

  localparam int unsigned EXP_W = COORD_WIDTH + OUT_FRAC_BITS;
  localparam int unsigned INV_W = EXP_W + 1;
  localparam int unsigned NCH   = (INV_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned CNT_W = $clog2(EXP_W + 1);

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(EXP_W);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(NCH - 1);

  state_e           state_q, state_d;
  axis_e            axis_q, axis_d, axis_next;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AX_X;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    case (axis_q)
      AX_X:    axis_next = AX_Y;
      AX_Y:    axis_next = AX_Z;
      default: axis_next = AX_X;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.axis  = axis_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!in_pass_i) begin
            cmd_o.upd_bounds = 1'b1;
          end else begin
            cmd_o.load_point = 1'b1;
            axis_d           = AX_X;
            if (in_first_i) begin
              cmd_o.span_clr = 1'b1;
              state_d        = ST_SPAN;
            end else begin
              state_d = ST_MLOAD;
            end
          end
        end
      end
      ST_SPAN: begin
        cmd_o.span_step = 1'b1;
        if (axis_q == AX_Z) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = ST_DIV;
        end else begin
          axis_d = axis_next;
        end
      end
      ST_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
        if (cnt_q == DIV_LAST) begin
          axis_d  = AX_X;
          state_d = ST_MLOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        cnt_d          = '0;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == MUL_LAST) begin
          state_d = ST_NSTORE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_NSTORE: begin
        cmd_o.norm_store = 1'b1;
        if (axis_q == AX_Z) begin
          state_d = ST_OUT;
        end else begin
          axis_d  = axis_next;
          state_d = ST_MLOAD;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/bbn_dpath.sv @@
// ----------------------------------------------------------------------------
// bbn_dpath
// bounds, span, restoring divider, chunked multiplier and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module bbn_dpath #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbn_pkg::bbn_cmd_t             cmd_i,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  logic signed [COORD_WIDTH-1:0] coord_z_i,
  input  logic                          first_i,
  input  logic                          last_i,
  output logic [OUT_FRAC_BITS:0]        norm_x_o,
  output logic [OUT_FRAC_BITS:0]        norm_y_o,
  output logic [OUT_FRAC_BITS:0]        norm_z_o,
  output logic                          is_last_o,
  output logic [COORD_WIDTH-1:0]        span_o,
  output logic signed [COORD_WIDTH-1:0] low_x_o,
  output logic signed [COORD_WIDTH-1:0] low_y_o,
  output logic signed [COORD_WIDTH-1:0] low_z_o
);
  import bbn_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned EXP_W  = CW + OUT_FRAC_BITS;
  localparam int unsigned INV_W  = EXP_W + 1;
  localparam int unsigned NCH    = (INV_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned PADW   = NCH * CHUNK_W;
  localparam int unsigned ACC_W  = CW + PADW;
  localparam int unsigned NORM_W = OUT_FRAC_BITS + 1;

  localparam logic [INV_W-1:0]  INV_RESET = INV_W'(1) << CW;
  localparam logic [NORM_W-1:0] NORM_ONE  = NORM_W'(1) << OUT_FRAC_BITS;

  logic signed [CW-1:0] coord_in [AXES];
  logic signed [CW-1:0] least_q  [AXES];
  logic signed [CW-1:0] most_q   [AXES];
  logic signed [CW-1:0] pt_q     [AXES];
  logic [NORM_W-1:0]    norm_q   [AXES];
  logic                 last_q;

  logic signed [CW-1:0] least_sel, most_sel, pt_sel;
  logic [CW:0]          span_diff, pt_diff;
  logic [CW-1:0]        axis_span, d_next;

  logic [CW-1:0]        span_q;
  logic [CW-1:0]        divisor;
  logic [CW-1:0]        rem_q;
  logic [CW:0]          rem_sh, rem_next;
  logic                 rem_ge;
  logic [INV_W-1:0]     inv_q;

  logic [CW-1:0]         d_q;
  logic [PADW-1:0]       iw_q;
  logic [ACC_W-1:0]      acc_q, acc_next;
  logic [CHUNK_W-1:0]    chunk;
  logic [CW+CHUNK_W-1:0] pp;
  logic                  sat;
  logic [NORM_W-1:0]     norm_val;

  assign coord_in[0] = coord_x_i;
  assign coord_in[1] = coord_y_i;
  assign coord_in[2] = coord_z_i;

  // per-axis bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        least_q[a] <= '0;
        most_q[a]  <= '0;
      end
    end else if (cmd_i.upd_bounds) begin
      for (int a = 0; a < AXES; a++) begin
        if (first_i) begin
          least_q[a] <= coord_in[a];
          most_q[a]  <= coord_in[a];
        end else begin
          if (coord_in[a] < least_q[a]) least_q[a] <= coord_in[a];
          if (coord_in[a] > most_q[a])  most_q[a]  <= coord_in[a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_point) begin
      for (int a = 0; a < AXES; a++) begin
        pt_q[a] <= coord_in[a];
      end
      last_q <= last_i;
    end
  end

  always_comb begin
    case (cmd_i.axis)
      AX_Y: begin
        least_sel = least_q[1];
        most_sel  = most_q[1];
        pt_sel    = pt_q[1];
      end
      AX_Z: begin
        least_sel = least_q[2];
        most_sel  = most_q[2];
        pt_sel    = pt_q[2];
      end
      default: begin
        least_sel = least_q[0];
        most_sel  = most_q[0];
        pt_sel    = pt_q[0];
      end
    endcase
  end

  assign span_diff = {most_sel[CW-1], most_sel} - {least_sel[CW-1], least_sel};
  assign axis_span = (!span_diff[CW] && (span_diff != '0)) ? span_diff[CW-1:0] : '0;
  assign pt_diff   = {pt_sel[CW-1], pt_sel} - {least_sel[CW-1], least_sel};
  assign d_next    = (!pt_diff[CW] && (pt_diff != '0)) ? pt_diff[CW-1:0] : '0;

  // widest span
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0;
    end else if (cmd_i.span_clr) begin
      span_q <= '0;
    end else if (cmd_i.span_step && (axis_span > span_q)) begin
      span_q <= axis_span;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign divisor  = (span_q == '0) ? CW'(1) : span_q;
  assign rem_sh   = {rem_q, cmd_i.div_first};
  assign rem_ge   = (rem_sh >= {1'b0, divisor});
  assign rem_next = rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= INV_RESET;
    end else if (cmd_i.div_step) begin
      inv_q <= {inv_q[INV_W-2:0], rem_ge};
    end
  end

  // multiply, most significant reciprocal chunk first
  assign chunk    = iw_q[PADW-1 -: CHUNK_W];
  assign pp       = d_q * chunk;
  assign acc_next = {acc_q[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(pp);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      d_q   <= d_next;
      iw_q  <= PADW'(inv_q);
      acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      acc_q <= acc_next;
      iw_q  <= iw_q << CHUNK_W;
    end
  end

  assign sat      = |acc_q[ACC_W-1:EXP_W];
  assign norm_val = sat ? NORM_ONE : NORM_W'(acc_q[EXP_W-1:CW]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm_store) begin
      case (cmd_i.axis)
        AX_Y:    norm_q[1] <= norm_val;
        AX_Z:    norm_q[2] <= norm_val;
        default: norm_q[0] <= norm_val;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      norm_x_o  <= norm_q[0];
      norm_y_o  <= norm_q[1];
      norm_z_o  <= norm_q[2];
      is_last_o <= last_q;
      span_o    <= span_q;
      low_x_o   <= least_q[0];
      low_y_o   <= least_q[1];
      low_z_o   <= least_q[2];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bounding_box_normalizer.sv @@
// ----------------------------------------------------------------------------
// bounding_box_normalizer
// two-pass min-max normalisation of a 3d point cloud into the unit cube
//
//   channel  dir  modport  transaction
//   pt_i     in   sink     one point: coords, pass, first, last
//   res_o    out  source   one normalised point with span and axis minimums
//
// a pass-0 point only updates the bounds. a pass-1 point runs, for each axis,
// a load, NCH = ceil((COORD_WIDTH+OUT_FRAC_BITS+1)/16) reciprocal chunks
// through the shared 16-bit-wide multiplier and a store, then the output step.
// a pass-1 point flagged first runs the span search over the three axes and
// the divider ahead of that work. reset is asynchronous and needs no sweep.
// the result register holds a finished point while the next is accepted;
// a stalled result only holds back the next pass-1 point at its output step.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_box_normalizer #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbn_in_if.sink     pt_i,
  bbn_out_if.source  res_o
);
  import bbn_pkg::*;

  localparam logic [OUT_FRAC_BITS:0] NORM_ONE = {1'b1, {OUT_FRAC_BITS{1'b0}}};

  bbn_cmd_t cmd;

  bbn_ctrl #(
    .COORD_WIDTH   (COORD_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pt_i.valid),
    .in_pass_i   (pt_i.pass),
    .in_first_i  (pt_i.first),
    .in_ready_o  (pt_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd)
  );

  bbn_dpath #(
    .COORD_WIDTH   (COORD_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .coord_x_i (pt_i.coord_x),
    .coord_y_i (pt_i.coord_y),
    .coord_z_i (pt_i.coord_z),
    .first_i   (pt_i.first),
    .last_i    (pt_i.last),
    .norm_x_o  (res_o.norm_x),
    .norm_y_o  (res_o.norm_y),
    .norm_z_o  (res_o.norm_z),
    .is_last_o (res_o.is_last),
    .span_o    (res_o.span),
    .low_x_o   (res_o.low_x),
    .low_y_o   (res_o.low_y),
    .low_z_o   (res_o.low_z)
  );

  // pass-0 points never raise a result
  a_pass0_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_i.valid && pt_i.ready && !pt_i.pass && !res_o.valid) |=> !res_o.valid)
    else $error("result raised by a pass-0 point");

  // a pass-1 point keeps the input closed while it is worked on
  a_pass1_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_i.valid && pt_i.ready && pt_i.pass) |=> !pt_i.ready)
    else $error("input reopened during pass-1 work");

  // normalised coordinates never exceed 1.0
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.norm_x <= NORM_ONE) && (res_o.norm_y <= NORM_ONE) &&
                    (res_o.norm_z <= NORM_ONE))
    else $error("normalised coordinate above 1.0");

endmodule

`default_nettype wire
